/* rtl/sjsi_pkg.sv */
// sjsi_pkg: shared types, constants and joint tables for the servo interpolator
// no dependencies
`default_nettype none
package sjsi_pkg;
    localparam int JOINT_COUNT = 6;
    localparam int FRAC_BITS   = 16;
    localparam int JW          = $clog2(JOINT_COUNT) > 0 ? $clog2(JOINT_COUNT) : 1;
    localparam int QW          = FRAC_BITS + 1;
    localparam int STEP_W      = 10;
    localparam int IVL_W       = 8;
    localparam int ANG_W       = 10;
    localparam int PULSE_W     = 12;
    localparam int PULSE_MIN   = 500;
    localparam int PULSE_SPAN  = 2000;
    localparam int RESET_STEPS = 160;
    localparam int RESET_IVL   = 12;
    localparam int RCP9        = 58255;
    localparam int RCP27       = 77673;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_START = 2'd1,
        FN_STOP  = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_T2, ST_T3, ST_P, ST_S, ST_JOINT, ST_PULSE, ST_OUT
    } t_state;

    typedef struct packed {
        logic div_start;
        logic mul_t2;
        logic mul_t3;
        logic mul_p;
        logic mul_s;
        logic joint_calc;
        logic pulse_calc;
        logic joint_next;
        logic step_done;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last_joint;
    } t_sts;

    function automatic logic signed [ANG_W-1:0] lim_lo(input logic [JW-1:0] j);
        unique case (j)
            3'd0: lim_lo = 10'sd0;
            3'd1: lim_lo = 10'sd10;
            3'd2: lim_lo = 10'sd20;
            3'd3: lim_lo = 10'sd20;
            3'd4: lim_lo = 10'sd10;
            3'd5: lim_lo = 10'sd10;
            default: lim_lo = 10'sd0;
        endcase
    endfunction

    function automatic logic signed [ANG_W-1:0] lim_hi(input logic [JW-1:0] j);
        unique case (j)
            3'd0: lim_hi = 10'sd180;
            3'd1: lim_hi = 10'sd170;
            3'd2: lim_hi = 10'sd160;
            3'd3: lim_hi = 10'sd160;
            3'd4: lim_hi = 10'sd170;
            3'd5: lim_hi = 10'sd260;
            default: lim_hi = 10'sd180;
        endcase
    endfunction

    function automatic logic signed [ANG_W-1:0] home(input logic [JW-1:0] j);
        unique case (j)
            3'd0: home = 10'sd30;
            3'd1: home = 10'sd110;
            3'd2: home = 10'sd100;
            3'd3: home = 10'sd80;
            3'd4: home = 10'sd140;
            3'd5: home = 10'sd158;
            default: home = 10'sd0;
        endcase
    endfunction

    // pulse offset = a*2000/span by reciprocal multiplication, exact for a below 512
    function automatic logic [PULSE_W-1:0] pulse_of(input logic [JW-1:0] j,
                                                    input logic [8:0] a);
        logic [16:0] x;
        logic [33:0] q;
        if (j == 3'd5) begin
            x = 17'(a) * 17'd200;
            q = (34'(x) * 34'(RCP27)) >> 21;
        end else begin
            x = 17'(a) * 17'd100;
            q = (34'(x) * 34'(RCP9)) >> 19;
        end
        pulse_of = PULSE_W'(PULSE_MIN) + PULSE_W'(q);
    endfunction
endpackage
`default_nettype wire

/* rtl/sjsi_ctrl.sv */
// sjsi_ctrl: sequencer for one interpolation step
// depends on sjsi_pkg
`default_nettype none
module sjsi_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step_go,
    input  wire logic            i_out_taken,
    input  wire sjsi_pkg::t_sts  i_sts,
    output sjsi_pkg::t_cmd       o_cmd,
    output logic                 o_busy,
    output logic                 o_out_valid
);
    sjsi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sjsi_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sjsi_pkg::ST_IDLE:  if (i_step_go) n_state = sjsi_pkg::ST_DIV;
            sjsi_pkg::ST_DIV:   if (i_sts.div_done) n_state = sjsi_pkg::ST_T2;
            sjsi_pkg::ST_T2:    n_state = sjsi_pkg::ST_T3;
            sjsi_pkg::ST_T3:    n_state = sjsi_pkg::ST_P;
            sjsi_pkg::ST_P:     n_state = sjsi_pkg::ST_S;
            sjsi_pkg::ST_S:     n_state = sjsi_pkg::ST_JOINT;
            sjsi_pkg::ST_JOINT: n_state = sjsi_pkg::ST_PULSE;
            sjsi_pkg::ST_PULSE: n_state = i_sts.last_joint ? sjsi_pkg::ST_OUT
                                                           : sjsi_pkg::ST_JOINT;
            sjsi_pkg::ST_OUT:   if (i_out_taken) n_state = sjsi_pkg::ST_IDLE;
            default:            n_state = sjsi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != sjsi_pkg::ST_IDLE);
        o_out_valid = (r_state == sjsi_pkg::ST_OUT);
        unique case (r_state)
            sjsi_pkg::ST_IDLE:  o_cmd.div_start = i_step_go;
            sjsi_pkg::ST_T2:    o_cmd.mul_t2 = 1'b1;
            sjsi_pkg::ST_T3:    o_cmd.mul_t3 = 1'b1;
            sjsi_pkg::ST_P:     o_cmd.mul_p = 1'b1;
            sjsi_pkg::ST_S:     o_cmd.mul_s = 1'b1;
            sjsi_pkg::ST_JOINT: o_cmd.joint_calc = 1'b1;
            sjsi_pkg::ST_PULSE: begin
                o_cmd.pulse_calc = 1'b1;
                o_cmd.joint_next = 1'b1;
                o_cmd.step_done = i_sts.last_joint;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/sjsi_dp.sv */
// sjsi_dp: divider, easing multiplier and per-joint blend and pulse mapping
// depends on sjsi_pkg
`default_nettype none
module sjsi_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire sjsi_pkg::t_cmd                         i_cmd,
    input  wire logic                                   i_load,
    input  wire logic signed [sjsi_pkg::ANG_W-1:0]      i_tgt [sjsi_pkg::JOINT_COUNT],
    input  wire logic [sjsi_pkg::STEP_W-1:0]            i_step,
    input  wire logic [sjsi_pkg::STEP_W-1:0]            i_total,
    output sjsi_pkg::t_sts                              o_sts,
    output logic [sjsi_pkg::PULSE_W-1:0]                o_pulse [sjsi_pkg::JOINT_COUNT]
);
    localparam int F  = sjsi_pkg::FRAC_BITS;
    localparam int QW = sjsi_pkg::QW;
    localparam int NW = sjsi_pkg::STEP_W + F + 1;
    localparam int DW = sjsi_pkg::STEP_W;
    localparam int CW = $clog2(NW + 1);
    localparam int JW = sjsi_pkg::JW;
    localparam int AW = sjsi_pkg::ANG_W;

    logic signed [AW-1:0] r_cur [sjsi_pkg::JOINT_COUNT];
    logic signed [AW-1:0] r_start [sjsi_pkg::JOINT_COUNT];
    logic signed [AW-1:0] r_tg [sjsi_pkg::JOINT_COUNT];
    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_div_busy, r_full;
    logic [QW-1:0] r_t, r_t2, r_t3, r_s;
    logic [QW+3:0] r_p;
    logic [JW-1:0] r_j;
    logic signed [AW-1:0] r_ang;

    logic [DW:0]  n_rem;
    logic [2*QW+3:0] w_ts, w_6tt;
    logic [QW+3:0] w_p;
    logic signed [AW:0] w_d;
    logic [AW:0]  w_ad;
    logic [AW+QW:0] w_m;
    logic [8:0]   w_clamp;
    logic signed [AW-1:0] w_cl;

    assign n_rem = {r_rem[DW-1:0], r_quo[NW-1]};
    assign o_sts.div_done = r_div_busy && (r_cnt == '0);
    assign o_sts.last_joint = (r_j == JW'(sjsi_pkg::JOINT_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_j <= '0;
            for (int j = 0; j < sjsi_pkg::JOINT_COUNT; j++)
                r_cur[j] <= sjsi_pkg::home(JW'(j));
        end else begin
            if (i_load) begin
                for (int j = 0; j < sjsi_pkg::JOINT_COUNT; j++) begin
                    r_start[j] <= r_cur[j];
                    r_tg[j] <= i_tgt[j];
                end
            end
            // restoring division, one quotient bit a cycle
            if (i_cmd.div_start) begin
                r_full <= ({1'b0, i_step} + 11'd1) >= {1'b0, i_total};
                r_quo <= NW'({i_step + 10'd1, F'(0)});
                r_rem <= '0;
                r_cnt <= CW'(NW);
                r_div_busy <= 1'b1;
            end else if (r_div_busy) begin
                if (r_cnt == '0) begin
                    r_div_busy <= 1'b0;
                    r_t <= r_full ? QW'(1 << F) : r_quo[QW-1:0];
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    if (n_rem >= {1'b0, i_total}) begin
                        r_rem <= n_rem - {1'b0, i_total};
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                end
            end
            if (i_cmd.mul_t2) r_t2 <= QW'(w_ts >> F);
            if (i_cmd.mul_t3) r_t3 <= QW'(w_ts >> F);
            if (i_cmd.mul_p)  r_p <= w_p;
            if (i_cmd.mul_s) begin
                r_s <= ((w_ts >> F) > (2*QW+4)'(1 << F)) ? QW'(1 << F) : QW'(w_ts >> F);
                r_j <= '0;
            end
            if (i_cmd.joint_calc) begin
                r_ang <= w_cl;
                r_cur[r_j] <= w_cl;
            end
            if (i_cmd.pulse_calc) o_pulse[r_j] <= sjsi_pkg::pulse_of(r_j, w_clamp);
            if (i_cmd.joint_next && !o_sts.last_joint) r_j <= r_j + 1'b1;
        end
    end

    // shared multiplier operands
    always_comb begin
        if (i_cmd.mul_t2)      w_ts = (2*QW+4)'(r_t) * (2*QW+4)'(r_t);
        else if (i_cmd.mul_t3) w_ts = (2*QW+4)'(r_t2) * (2*QW+4)'(r_t);
        else                   w_ts = (2*QW+4)'(r_t3) * (2*QW+4)'(r_p);
    end
    // 6*t*t taken in full before the shift keeps the truncation of 6*t*t>>F
    assign w_6tt = ((2*QW+4)'(r_t) * (2*QW+4)'(r_t)) * (2*QW+4)'(6);
    assign w_p = (QW+4)'(w_6tt >> F) + (QW+4)'(10 << F) - (QW+4)'(r_t) * (QW+4)'(15);

    always_comb begin
        w_d  = (AW+1)'(r_tg[r_j]) - (AW+1)'(r_start[r_j]);
        w_ad = w_d[AW] ? (AW+1)'(-w_d) : (AW+1)'(w_d);
        w_m  = ((AW+QW+1)'(w_ad) * (AW+QW+1)'(r_s)) >> F;
        w_cl = w_d[AW] ? AW'(r_start[r_j] - AW'(w_m)) : AW'(r_start[r_j] + AW'(w_m));
        if (r_ang < sjsi_pkg::lim_lo(r_j))      w_clamp = 9'(sjsi_pkg::lim_lo(r_j));
        else if (r_ang > sjsi_pkg::lim_hi(r_j)) w_clamp = 9'(sjsi_pkg::lim_hi(r_j));
        else                                    w_clamp = 9'(r_ang);
    end
endmodule
`default_nettype wire

/* rtl/six_joint_scurve_servo_interpolator_unit.sv */
// six_joint_scurve_servo_interpolator_unit: top level, command decode and move state
// depends on sjsi_pkg, sjsi_ctrl, sjsi_dp
//
// channel | direction | handshake            | word
// in      | input     | i_valid / o_stall    | func, six targets, steps, interval
// out     | output    | o_valid / i_stall    | six pulses, still_moving
//
// a tick that triggers a step holds the input while the bit-serial divider, the easing
// steps t2, t3, p and s, the blend and pulse of each joint and the result word run
// in turn; an output stall lengthens the hold
// other words do not hold the input; input stalls while a step is in flight or waiting
// reset is synchronous, active low; pose returns to the home position
`default_nettype none
module six_joint_scurve_servo_interpolator_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [1:0]                         i_func,
    input  wire logic signed [sjsi_pkg::ANG_W-1:0]  i_target_gripper,
    input  wire logic signed [sjsi_pkg::ANG_W-1:0]  i_target_wrist_roll,
    input  wire logic signed [sjsi_pkg::ANG_W-1:0]  i_target_shoulder,
    input  wire logic signed [sjsi_pkg::ANG_W-1:0]  i_target_elbow,
    input  wire logic signed [sjsi_pkg::ANG_W-1:0]  i_target_wrist_pitch,
    input  wire logic signed [sjsi_pkg::ANG_W-1:0]  i_target_base,
    input  wire logic [sjsi_pkg::STEP_W-1:0]        i_move_steps,
    input  wire logic [sjsi_pkg::IVL_W-1:0]         i_step_interval_ms,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [sjsi_pkg::PULSE_W-1:0]            o_pulse_gripper,
    output logic [sjsi_pkg::PULSE_W-1:0]            o_pulse_wrist_roll,
    output logic [sjsi_pkg::PULSE_W-1:0]            o_pulse_shoulder,
    output logic [sjsi_pkg::PULSE_W-1:0]            o_pulse_elbow,
    output logic [sjsi_pkg::PULSE_W-1:0]            o_pulse_wrist_pitch,
    output logic [sjsi_pkg::PULSE_W-1:0]            o_pulse_base,
    output logic                                    o_still_moving
);
    logic [sjsi_pkg::STEP_W-1:0] r_step, r_total;
    logic [sjsi_pkg::IVL_W-1:0]  r_ivl, r_tick;
    logic r_moving, r_stop;
    logic w_acc, w_go, w_load, w_busy;
    logic [sjsi_pkg::IVL_W-1:0] w_tick1;
    logic [sjsi_pkg::STEP_W-1:0] w_step1;
    logic signed [sjsi_pkg::ANG_W-1:0] w_tgt [sjsi_pkg::JOINT_COUNT];
    logic [sjsi_pkg::PULSE_W-1:0] w_pulse [sjsi_pkg::JOINT_COUNT];
    sjsi_pkg::t_cmd w_cmd;
    sjsi_pkg::t_sts w_sts;
    sjsi_pkg::t_func w_func;

    assign w_func = sjsi_pkg::t_func'(i_func);
    assign o_stall = w_busy;
    assign w_acc = i_valid && !w_busy;
    assign w_tick1 = r_tick + 1'b1;
    assign w_go = w_acc && (w_func == sjsi_pkg::FN_TICK) && r_moving && !r_stop
                  && (w_tick1 >= r_ivl);
    assign w_load = w_acc && (w_func == sjsi_pkg::FN_START) && !r_stop;
    assign w_step1 = r_step + 1'b1;
    assign w_tgt[0] = i_target_gripper;
    assign w_tgt[1] = i_target_wrist_roll;
    assign w_tgt[2] = i_target_shoulder;
    assign w_tgt[3] = i_target_elbow;
    assign w_tgt[4] = i_target_wrist_pitch;
    assign w_tgt[5] = i_target_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_total <= sjsi_pkg::STEP_W'(sjsi_pkg::RESET_STEPS);
            r_ivl <= sjsi_pkg::IVL_W'(sjsi_pkg::RESET_IVL);
            r_tick <= '0;
            r_moving <= 1'b0;
            r_stop <= 1'b0;
            o_still_moving <= 1'b0;
        end else begin
            if (w_acc) begin
                unique case (w_func)
                    sjsi_pkg::FN_START: if (!r_stop) begin
                        r_total <= i_move_steps;
                        r_ivl <= i_step_interval_ms;
                        r_step <= '0;
                        r_tick <= '0;
                        r_moving <= 1'b1;
                    end
                    sjsi_pkg::FN_STOP: begin
                        r_stop <= 1'b1;
                        r_moving <= 1'b0;
                    end
                    sjsi_pkg::FN_CLEAR: r_stop <= 1'b0;
                    sjsi_pkg::FN_TICK: if (r_moving && !r_stop) begin
                        r_tick <= (w_tick1 >= r_ivl) ? '0 : w_tick1;
                    end
                    default: ;
                endcase
            end
            if (w_cmd.step_done) begin
                r_step <= w_step1;
                r_moving <= !(w_step1 >= r_total);
                o_still_moving <= !(w_step1 >= r_total);
            end
        end
    end

    sjsi_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step_go(w_go),
        .i_out_taken(!i_stall), .i_sts(w_sts), .o_cmd(w_cmd),
        .o_busy(w_busy), .o_out_valid(o_valid)
    );

    sjsi_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_load(w_load),
        .i_tgt(w_tgt), .i_step(r_step), .i_total(r_total),
        .o_sts(w_sts), .o_pulse(w_pulse)
    );

    assign o_pulse_gripper = w_pulse[0];
    assign o_pulse_wrist_roll = w_pulse[1];
    assign o_pulse_shoulder = w_pulse[2];
    assign o_pulse_elbow = w_pulse[3];
    assign o_pulse_wrist_pitch = w_pulse[4];
    assign o_pulse_base = w_pulse[5];
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// tb_top: self-checking bench for six_joint_scurve_servo_interpolator_unit
// depends on sjsi_pkg and the unit; predicts pulse words from commands and ticks
// random gaps on both channels, a drain pause, and a watchdog on stalled traffic
`timescale 1ns / 1ps
module tb_top;
    localparam int WDOG_LIMIT = 4000;
    localparam logic [63:0] ONE = 64'd1 << sjsi_pkg::FRAC_BITS;

    typedef struct {
        sjsi_pkg::t_func fn;
        int tgt [6];
        int steps;
        int ivl;
        bit drain;
    } t_cmd_word;

    typedef struct {
        int pulse [6];
        bit moving;
    } t_pulse_word;

    logic i_clk, i_rst_n, i_valid, i_stall;
    logic [1:0] i_func;
    logic signed [sjsi_pkg::ANG_W-1:0] i_tg [6];
    logic [sjsi_pkg::STEP_W-1:0] i_move_steps;
    logic [sjsi_pkg::IVL_W-1:0] i_step_interval_ms;
    logic o_stall, o_valid, o_still_moving;
    logic [sjsi_pkg::PULSE_W-1:0] o_pulse [6];

    six_joint_scurve_servo_interpolator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func),
        .i_target_gripper(i_tg[0]), .i_target_wrist_roll(i_tg[1]),
        .i_target_shoulder(i_tg[2]), .i_target_elbow(i_tg[3]),
        .i_target_wrist_pitch(i_tg[4]), .i_target_base(i_tg[5]),
        .i_move_steps(i_move_steps), .i_step_interval_ms(i_step_interval_ms),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pulse_gripper(o_pulse[0]), .o_pulse_wrist_roll(o_pulse[1]),
        .o_pulse_shoulder(o_pulse[2]), .o_pulse_elbow(o_pulse[3]),
        .o_pulse_wrist_pitch(o_pulse[4]), .o_pulse_base(o_pulse[5]),
        .o_still_moving(o_still_moving)
    );

    t_cmd_word pending_cmds [$];
    t_pulse_word pulse_queue [$];
    bit run_fail, rst_done, in_taken, out_taken, burst_mode;
    int gap_left, stall_left, idle_cycles, words_made;

    // predictor state
    int pose [6], from_pose [6], to_pose [6];
    int step_cnt, step_total, ivl_len, tick_cnt;
    bit moving, stopped;

    const string joint_name [6] = '{"pulse_gripper", "pulse_wrist_roll", "pulse_shoulder",
                                    "pulse_elbow", "pulse_wrist_pitch", "pulse_base"};
    const int lo_deg [6] = '{0, 10, 20, 20, 10, 10};
    const int hi_deg [6] = '{180, 170, 160, 160, 170, 260};
    const int home_deg [6] = '{30, 110, 100, 80, 140, 158};

    function automatic logic [63:0] smootherstep(input logic [63:0] t);
        logic [63:0] t2, t3, p, s;
        t2 = (t * t) >> sjsi_pkg::FRAC_BITS;
        t3 = (t2 * t) >> sjsi_pkg::FRAC_BITS;
        p = ((64'd6 * t * t) >> sjsi_pkg::FRAC_BITS) + 64'd10 * ONE - 64'd15 * t;
        s = (t3 * p) >> sjsi_pkg::FRAC_BITS;
        return (s > ONE) ? ONE : s;
    endfunction

    task automatic advance_motion(input t_cmd_word w);
        logic [63:0] t, s, m;
        int d, a;
        t_pulse_word r;
        case (w.fn)
            sjsi_pkg::FN_START: begin
                if (!stopped) begin
                    for (int j = 0; j < 6; j++) begin
                        from_pose[j] = pose[j];
                        to_pose[j] = w.tgt[j];
                    end
                    step_total = w.steps;
                    ivl_len = w.ivl;
                    step_cnt = 0;
                    tick_cnt = 0;
                    moving = 1;
                end
            end
            sjsi_pkg::FN_STOP: begin
                stopped = 1;
                moving = 0;
            end
            sjsi_pkg::FN_CLEAR: stopped = 0;
            default: begin
                if (moving && !stopped) begin
                    tick_cnt = (tick_cnt + 1) & 8'hff;
                    if (tick_cnt >= ivl_len) begin
                        tick_cnt = 0;
                        if (step_cnt + 1 >= step_total) t = ONE;
                        else t = (64'(step_cnt + 1) << sjsi_pkg::FRAC_BITS)
                                 / 64'(step_total);
                        s = smootherstep(t);
                        for (int j = 0; j < 6; j++) begin
                            d = to_pose[j] - from_pose[j];
                            m = (64'(d < 0 ? -d : d) * s) >> sjsi_pkg::FRAC_BITS;
                            pose[j] = from_pose[j] + (d < 0 ? -int'(m) : int'(m));
                            a = pose[j];
                            if (a < lo_deg[j]) a = lo_deg[j];
                            if (a > hi_deg[j]) a = hi_deg[j];
                            r.pulse[j] = (500 + (a * 2000) / (j == 5 ? 270 : 180)) & 12'hfff;
                        end
                        step_cnt = (step_cnt + 1) & 10'h3ff;
                        if (step_cnt >= step_total) moving = 0;
                        r.moving = moving;
                        pulse_queue.push_back(r);
                    end
                end
            end
        endcase
    endtask

    task automatic add_word(input sjsi_pkg::t_func fn, input int tg [6], input int steps,
                            input int ivl, input bit drain = 0);
        t_cmd_word w;
        w.fn = fn;
        w.tgt = tg;
        w.steps = steps;
        w.ivl = ivl;
        w.drain = drain;
        pending_cmds.push_back(w);
        words_made++;
    endtask

    function automatic void rand_targets(output int tg [6]);
        for (int j = 0; j < 6; j++) tg[j] = int'($urandom_range(0, 288)) - 8;
    endfunction

    task automatic add_ticks(input int n);
        int z [6];
        z = '{0, 0, 0, 0, 0, 0};
        for (int k = 0; k < n; k++)
            add_word(sjsi_pkg::FN_TICK, z, $urandom_range(0, 1023), $urandom_range(0, 255));
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1;
            end else
                i_stall <= 0;
            if (out_taken) stall_left = burst_mode ? 0 : $urandom_range(0, 5);

            if (!i_valid || in_taken) begin
                if (in_taken) begin
                    gap_left = burst_mode ? 0 : $urandom_range(0, 5);
                    if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 0;
                end else if (pending_cmds.size() == 0 ||
                             (pending_cmds[0].drain && pulse_queue.size() != 0)) begin
                    i_valid <= 0;
                end else begin
                    t_cmd_word w;
                    w = pending_cmds.pop_front();
                    i_func <= w.fn;
                    for (int j = 0; j < 6; j++) i_tg[j] <= sjsi_pkg::ANG_W'(w.tgt[j]);
                    i_move_steps <= sjsi_pkg::STEP_W'(w.steps);
                    i_step_interval_ms <= sjsi_pkg::IVL_W'(w.ivl);
                    i_valid <= 1;
                end
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        bit acc_in, acc_out;
        acc_in = rst_done && i_valid && !o_stall;
        acc_out = rst_done && o_valid && !i_stall;
        in_taken <= acc_in;
        out_taken <= acc_out;
        if (rst_done) begin
            idle_cycles <= (acc_in || acc_out) ? 0 : idle_cycles + 1;
            if (acc_in) begin
                t_cmd_word w;
                w.fn = sjsi_pkg::t_func'(i_func);
                for (int j = 0; j < 6; j++) w.tgt[j] = int'(i_tg[j]);
                w.steps = i_move_steps;
                w.ivl = i_step_interval_ms;
                advance_motion(w);
            end
            if (acc_out) begin
                if (pulse_queue.size() == 0) begin
                    $error("unexpected pulse word");
                    run_fail = 1;
                end else begin
                    t_pulse_word e;
                    e = pulse_queue.pop_front();
                    for (int j = 0; j < 6; j++)
                        if (o_pulse[j] !== e.pulse[j]) begin
                            $error("%s expected %0d actual %0d", joint_name[j], e.pulse[j],
                                   o_pulse[j]);
                            run_fail = 1;
                        end
                    if (o_still_moving !== e.moving) begin
                        $error("still_moving expected %0d actual %0d", e.moving, o_still_moving);
                        run_fail = 1;
                    end
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("FAIL six_joint_scurve_servo_interpolator_unit");
                $finish;
            end
        end
    end

    initial begin
        int tg [6], n, r, steps, ivl;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_func = sjsi_pkg::FN_TICK;
        for (int j = 0; j < 6; j++) i_tg[j] = '0;
        i_move_steps = '0;
        i_step_interval_ms = '0;
        pose = home_deg;
        from_pose = '{0, 0, 0, 0, 0, 0};
        to_pose = '{0, 0, 0, 0, 0, 0};
        step_total = sjsi_pkg::RESET_STEPS;
        ivl_len = sjsi_pkg::RESET_IVL;

        // directed
        add_ticks(2);
        add_word(sjsi_pkg::FN_START, '{-8, -8, -8, -8, -8, -8}, 0, 0);
        add_ticks(2);
        add_word(sjsi_pkg::FN_START, '{280, 280, 280, 280, 280, 280}, 1, 1);
        add_ticks(1);
        add_word(sjsi_pkg::FN_START, '{-512, 511, 0, 200, -1, 280}, 3, 2, 1);
        add_ticks(7);
        add_word(sjsi_pkg::FN_START, '{90, 90, 90, 90, 90, 90}, 1023, 255);
        add_ticks(3);
        add_word(sjsi_pkg::FN_START, '{0, 170, 20, 160, 10, 260}, 4, 0);
        add_ticks(2);
        add_word(sjsi_pkg::FN_STOP, '{0, 0, 0, 0, 0, 0}, 0, 0);
        add_ticks(1);
        add_word(sjsi_pkg::FN_START, '{10, 10, 10, 10, 10, 10}, 2, 0);
        add_word(sjsi_pkg::FN_CLEAR, '{0, 0, 0, 0, 0, 0}, 0, 0);
        add_ticks(1);

        // random
        while (words_made < 1750) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                rand_targets(tg);
                steps = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, 12);
                ivl = (steps > 40) ? $urandom_range(0, 1) : $urandom_range(0, 4);
                add_word(sjsi_pkg::FN_START, tg, steps, ivl, $urandom_range(0, 29) == 0);
                n = (steps > 40) ? $urandom_range(1, 30) : (steps + 1) * (ivl > 0 ? ivl : 1);
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
                add_ticks(n + $urandom_range(0, 2));
            end else if (r < 86) begin
                add_ticks($urandom_range(1, 5));
            end else if (r < 93) begin
                add_word(sjsi_pkg::FN_STOP, '{0, 0, 0, 0, 0, 0}, $urandom_range(0, 1023),
                         $urandom_range(0, 255));
                if ($urandom_range(0, 2) != 0)
                    add_word(sjsi_pkg::FN_CLEAR, '{0, 0, 0, 0, 0, 0}, 0, 0);
            end else begin
                add_word(sjsi_pkg::FN_CLEAR, '{0, 0, 0, 0, 0, 0}, 0, 0);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        rst_done = 1;

        wait (pending_cmds.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (pulse_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!run_fail && pulse_queue.size() == 0)
            $display("PASS six_joint_scurve_servo_interpolator_unit");
        else
            $display("FAIL six_joint_scurve_servo_interpolator_unit");
        $finish;
    end
endmodule
